FILE: rtl/mxs_pkg.sv
package mxs_pkg;

   localparam int CELL_W    = 8;
   localparam int CFG_W     = 8;
   localparam int CNT_W     = 7;
   localparam int POS_W     = 7;
   localparam int SUM_OUT_W = 12;
   localparam int CSR_IDX_W = 2;
   localparam int ROWS_CAP  = 128;
   localparam int CNT_SPAN  = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd1;

   localparam logic [CFG_W-1:0] GRID_RESET = 8'd3;

   typedef struct packed {
      logic             valid;
      logic             in_blk;
      logic             frame_end;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
   } stage_ctrl_type;

   typedef struct packed {
      logic [SUM_OUT_W-1:0] best_sum;
      logic [POS_W-1:0]     best_row;
      logic [POS_W-1:0]     best_col;
      logic                 found;
   } result_type;

endpackage

FILE: rtl/mxs_if.sv
interface mxs_req_if;
   logic                      valid;
   logic                      ready;
   logic [mxs_pkg::CELL_W-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface mxs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mxs_pkg::SUM_OUT_W-1:0] best_sum;
   logic [mxs_pkg::POS_W-1:0]     best_row;
   logic [mxs_pkg::POS_W-1:0]     best_col;
   logic                         found;

   modport source (output valid, output best_sum, output best_row, output best_col,
                   output found, input ready);
   modport sink   (input valid, input best_sum, input best_row, input best_col,
                   input found, output ready);
endinterface

interface mxs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mxs_pkg::CSR_IDX_W-1:0] index;
   logic [mxs_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mxs_line_buf.sv
module mxs_line_buf #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int VB    = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mxs_pkg::stage_ctrl_type s0_ctrl,
   input  logic [AW-1:0]           s0_addr,
   input  logic [VB-1:0]           s0_cell,
   output mxs_pkg::stage_ctrl_type s1_ctrl,
   output logic [VB-1:0]           col_top,
   output logic [VB-1:0]           col_mid,
   output logic [VB-1:0]           col_bot
);

   logic [VB-1:0] mem_a [DEPTH];
   logic [VB-1:0] mem_b [DEPTH];

   logic [VB-1:0]           rd_a_ff, rd_b_ff;
   mxs_pkg::stage_ctrl_type s1_ctrl_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic [VB-1:0]           s1_cell_ff;
   logic                    lw_valid_ff;
   logic [AW-1:0]           lw_addr_ff;
   logic [VB-1:0]           lw_a_ff, lw_b_ff;
   logic [DEPTH-1:0]        entry_ok_ff;

   logic          fwd, ok;
   logic [VB-1:0] a_raw, b_raw, a_old, b_old;

   // same-entry write in the read cycle is forwarded
   always_comb begin
      fwd   = lw_valid_ff && (lw_addr_ff == s1_addr_ff);
      a_raw = fwd ? lw_a_ff : rd_a_ff;
      b_raw = fwd ? lw_b_ff : rd_b_ff;
      ok    = entry_ok_ff[s1_addr_ff];
      a_old = ok ? a_raw : '0;
      b_old = ok ? b_raw : '0;
   end

   assign s1_ctrl = s1_ctrl_ff;
   assign col_top = b_old;
   assign col_mid = a_old;
   assign col_bot = s1_cell_ff;

   always_ff @(posedge clock) begin
      if (s0_ctrl.valid) begin
         rd_a_ff <= mem_a[s0_addr];
         rd_b_ff <= mem_b[s0_addr];
      end
      if (s1_ctrl_ff.valid) begin
         mem_a[s1_addr_ff] <= s1_cell_ff;
         mem_b[s1_addr_ff] <= a_old;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= s0_addr;
      s1_cell_ff <= s0_cell;
      lw_addr_ff <= s1_addr_ff;
      lw_a_ff    <= s1_cell_ff;
      lw_b_ff    <= a_old;
      if (reset) begin
         s1_ctrl_ff  <= '0;
         lw_valid_ff <= 1'b0;
         entry_ok_ff <= '0;
      end else begin
         s1_ctrl_ff  <= s0_ctrl;
         lw_valid_ff <= s1_ctrl_ff.valid;
         if (s1_ctrl_ff.valid) begin
            if (s1_ctrl_ff.frame_end) begin
               entry_ok_ff <= '0;
            end else begin
               entry_ok_ff[s1_addr_ff] <= 1'b1;
            end
         end
      end
   end

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      s1_ctrl_ff.valid && s1_ctrl_ff.frame_end |=> entry_ok_ff == '0)
      else $error("line store entries still marked after frame end");

   a_entry_marked: assert property (@(posedge clock) disable iff (reset)
      s1_ctrl_ff.valid && !s1_ctrl_ff.frame_end |=> entry_ok_ff[lw_addr_ff])
      else $error("written line store entry not marked");

endmodule

FILE: rtl/max_3x3_window_sum.sv
// Best 3x3 block sum over a streamed grid.
// req_bus: one cell word per handshake, raster order, grid_rows x grid_cols.
// csr_bus: index 0 = grid_rows, index 1 = grid_cols (8 bits each, reset 3);
//   always ready, takes effect on the next accepted cell.
// rsp_bus: one word at the last cell of each frame: best_sum, its 1-based
//   top row and left column, and found (zero fields when nothing found).
// Throughput: one cell per clock while req_bus.ready is high. The two line stores share one
//   read/write port pair; a read in the accept cycle and the write-back in the
//   cycle after it, with forwarding, set that rate.
// Result path: line store (s1), window (s2) and sum (s3) registers, then the result buffer.
// Results queue in a 4-word buffer; req_bus.ready drops only while four
//   results are owed and unread, so a stalled receiver holds the input
//   back only once that many frames have ended.
// Reset: counters, best and line store marks clear at once; no clearing
//   pass. The line store marks also clear at every frame end.
module max_3x3_window_sum #(
   parameter int MAX_COLS   = 128,
   parameter int VALUE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   mxs_req_if.sink     req_bus,
   mxs_rsp_if.source   rsp_bus,
   mxs_csr_if.sink     csr_bus
);

   localparam int VB      = (VALUE_BITS > mxs_pkg::CELL_W) ? mxs_pkg::CELL_W : VALUE_BITS;
   localparam int SUMW    = VB + 4;
   localparam int DEPTH   = (MAX_COLS > mxs_pkg::CNT_SPAN) ? mxs_pkg::CNT_SPAN : MAX_COLS;
   localparam int AW      = $clog2(DEPTH);
   localparam int COL_CAP = (MAX_COLS > 255) ? 255 : MAX_COLS;
   localparam int QD      = 4;
   localparam int QW      = 2;
   localparam int PW      = 3;
   localparam int CW      = mxs_pkg::CNT_W;
   localparam int FW      = mxs_pkg::CFG_W;

   localparam logic [FW-1:0] COL_CAP_V = FW'(COL_CAP);
   localparam logic [FW-1:0] ROW_CAP_V = FW'(mxs_pkg::ROWS_CAP);

   logic [FW-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [FW-1:0] rows_eff, cols_eff;
   logic [CW-1:0] row_ff, col_ff;
   logic          accept, row_end, frame_end, in_blk;
   logic [AW-1:0] col_map [mxs_pkg::CNT_SPAN];

   mxs_pkg::stage_ctrl_type s0_ctrl, s1_ctrl, s2_ctrl_ff, s3_ctrl_ff;
   logic [VB-1:0]           col_top, col_mid, col_bot;
   logic [VB-1:0]           win_ff [3][3];
   logic [SUMW-1:0]         sum_in, sum_ff;

   logic [SUMW-1:0] best_ff, nb;
   logic [CW-1:0]   best_top_ff, best_left_ff, nt, nl;
   logic            take, push, pop;

   mxs_pkg::result_type q_ff [QD];
   mxs_pkg::result_type q_in;
   logic [QW-1:0]       wp_ff, rp_ff;
   logic [PW-1:0]       q_cnt_ff, pend_ff;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= mxs_pkg::GRID_RESET;
         cols_cfg_ff <= mxs_pkg::GRID_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mxs_pkg::CSR_GRID_ROWS: rows_cfg_ff <= csr_bus.data;
            mxs_pkg::CSR_GRID_COLS: cols_cfg_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_cfg_ff == '0)          rows_eff = FW'(1);
      else if (rows_cfg_ff > ROW_CAP_V) rows_eff = ROW_CAP_V;
      else                            rows_eff = rows_cfg_ff;
      if (cols_cfg_ff == '0)          cols_eff = FW'(1);
      else if (cols_cfg_ff > COL_CAP_V) cols_eff = COL_CAP_V;
      else                            cols_eff = cols_cfg_ff;
   end

   // position tracking, accept stage
   for (genvar i = 0; i < mxs_pkg::CNT_SPAN; i++) begin : g_col_map
      assign col_map[i] = AW'(i % MAX_COLS);
   end

   assign req_bus.ready = (pend_ff < PW'(QD));
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      row_end   = ({1'b0, col_ff} + FW'(1)) >= cols_eff;
      frame_end = row_end && (({1'b0, row_ff} + FW'(1)) >= rows_eff);
      in_blk    = (row_ff >= CW'(2)) && (col_ff >= CW'(2)) &&
                  ({1'b0, row_ff} < rows_eff) && ({1'b0, col_ff} < cols_eff);
      s0_ctrl.valid     = accept;
      s0_ctrl.in_blk    = in_blk;
      s0_ctrl.frame_end = frame_end;
      s0_ctrl.row       = row_ff;
      s0_ctrl.col       = col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (frame_end) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (row_end) begin
            row_ff <= row_ff + CW'(1);
            col_ff <= '0;
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   mxs_line_buf #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .VB    (VB)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .s0_ctrl (s0_ctrl),
      .s0_addr (col_map[col_ff]),
      .s0_cell (req_bus.cell_value[VB-1:0]),
      .s1_ctrl (s1_ctrl),
      .col_top (col_top),
      .col_mid (col_mid),
      .col_bot (col_bot)
   );

   // window shift
   always_ff @(posedge clock) begin
      if (s1_ctrl.valid) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= col_top;
         win_ff[1][2] <= col_mid;
         win_ff[2][2] <= col_bot;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sum_in = sum_in + SUMW'(win_ff[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (reset) begin
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
      end else begin
         s2_ctrl_ff <= s1_ctrl;
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   // best tracking; strict compare keeps the earliest block on a tie
   always_comb begin
      take = s3_ctrl_ff.valid && s3_ctrl_ff.in_blk && (sum_ff > best_ff);
      nb   = take ? sum_ff : best_ff;
      nt   = take ? (s3_ctrl_ff.row - CW'(1)) : best_top_ff;
      nl   = take ? (s3_ctrl_ff.col - CW'(1)) : best_left_ff;
      push = s3_ctrl_ff.valid && s3_ctrl_ff.frame_end;
      q_in.best_sum = mxs_pkg::SUM_OUT_W'(nb);
      q_in.best_row = nt;
      q_in.best_col = nl;
      q_in.found    = (nb != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         best_top_ff  <= '0;
         best_left_ff <= '0;
      end else if (push) begin
         best_ff      <= '0;
         best_top_ff  <= '0;
         best_left_ff <= '0;
      end else if (take) begin
         best_ff      <= nb;
         best_top_ff  <= nt;
         best_left_ff <= nl;
      end
   end

   // result buffer
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid = (q_cnt_ff != '0);
   assign rsp_bus.best_sum = q_ff[rp_ff].best_sum;
   assign rsp_bus.best_row = q_ff[rp_ff].best_row;
   assign rsp_bus.best_col = q_ff[rp_ff].best_col;
   assign rsp_bus.found    = q_ff[rp_ff].found;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         q_cnt_ff <= '0;
         pend_ff  <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QW'(1);
         if (pop)  rp_ff <= rp_ff + QW'(1);
         q_cnt_ff <= q_cnt_ff + PW'(push) - PW'(pop);
         pend_ff  <= pend_ff + PW'(accept && frame_end) - PW'(pop);
      end
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PW'(QD))
      else $error("owed results exceed buffer depth");

   a_queue_owed: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= pend_ff)
      else $error("buffered results exceed owed results");

   a_best_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> best_ff == '0 && best_top_ff == '0 && best_left_ff == '0)
      else $error("kept best not cleared after frame end");

endmodule

FILE: test/mxs_checker.sv
`timescale 1ns / 100ps

module mxs_checker
   import mxs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mxs_req_if   req_mon,
   mxs_rsp_if   rsp_mon,
   mxs_csr_if   csr_mon,
   output int   fail_count,
   output int   results_owed
);

   localparam int COL_CAP = 128;

   logic [CFG_W-1:0]     rows_cfg;
   logic [CFG_W-1:0]     cols_cfg;
   logic [CELL_W-1:0]    row_above [COL_CAP];
   logic [CELL_W-1:0]    row_above2 [COL_CAP];
   logic [CELL_W-1:0]    win [3][3];
   logic [CNT_W-1:0]     row_pos;
   logic [CNT_W-1:0]     col_pos;
   logic [SUM_OUT_W-1:0] top_sum;
   logic [POS_W-1:0]     top_row;
   logic [POS_W-1:0]     top_col;
   result_type           owed_results [$];

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic int clamp_span(input logic [CFG_W-1:0] v, input int cap);
      if (v == 0) return 1;
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   task automatic clear_frame();
      foreach (row_above[i]) begin
         row_above[i]  = '0;
         row_above2[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos = '0;
      col_pos = '0;
      top_sum = '0;
      top_row = '0;
      top_col = '0;
   endtask

   // one accepted word: slide the window, score the block, close the frame
   task automatic advance_window(input logic [CELL_W-1:0] in_value);
      int         rows;
      int         cols;
      int         c;
      int         sum;
      bit         row_end;
      bit         frame_end;
      result_type r;
      rows = clamp_span(rows_cfg, ROWS_CAP);
      cols = clamp_span(cols_cfg, COL_CAP);
      c = int'(col_pos);
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = row_above2[c];
      win[1][2] = row_above[c];
      win[2][2] = in_value;
      row_above2[c] = row_above[c];
      row_above[c]  = in_value;
      if (row_pos >= 2 && col_pos >= 2 && int'(row_pos) < rows && int'(col_pos) < cols) begin
         sum = 0;
         foreach (win[i, j]) sum += int'(win[i][j]);
         if (sum > int'(top_sum)) begin
            top_sum = sum[SUM_OUT_W-1:0];
            top_row = row_pos - 1'b1;
            top_col = col_pos - 1'b1;
         end
      end
      row_end   = int'(col_pos) + 1 >= cols;
      frame_end = row_end && (int'(row_pos) + 1 >= rows);
      if (frame_end) begin
         r.found    = (top_sum != 0);
         r.best_sum = r.found ? top_sum : '0;
         r.best_row = r.found ? top_row : '0;
         r.best_col = r.found ? top_col : '0;
         owed_results.push_back(r);
         clear_frame();
      end else if (row_end) begin
         col_pos = '0;
         row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         rows_cfg = GRID_RESET;
         cols_cfg = GRID_RESET;
         clear_frame();
         owed_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.best_sum = rsp_mon.best_sum;
            seen.best_row = rsp_mon.best_row;
            seen.best_col = rsp_mon.best_col;
            seen.found    = rsp_mon.found;
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("result word with nothing owed: sum %0d row %0d col %0d found %0b",
                               seen.best_sum, seen.best_row, seen.best_col, seen.found));
            end else begin
               want = owed_results.pop_front();
               if (seen.best_sum !== want.best_sum)
                  report_mismatch($sformatf("best_sum got %0d want %0d", seen.best_sum, want.best_sum));
               if (seen.best_row !== want.best_row)
                  report_mismatch($sformatf("best_row got %0d want %0d", seen.best_row, want.best_row));
               if (seen.best_col !== want.best_col)
                  report_mismatch($sformatf("best_col got %0d want %0d", seen.best_col, want.best_col));
               if (seen.found !== want.found)
                  report_mismatch($sformatf("found got %0b want %0b", seen.found, want.found));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_GRID_ROWS: rows_cfg = csr_mon.data;
               CSR_GRID_COLS: cols_cfg = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) advance_window(req_mon.cell_value);
      end
      results_owed <= owed_results.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mxs_pkg::*;

   localparam int TOTAL_CELLS   = 1250;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 5000;
   localparam int COL_CAP       = 128;

   typedef enum {FILL_ANY, FILL_LOW, FILL_SPARSE, FILL_ZERO, FILL_HIGH} fill_type;
   typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   owed;
   int   hold_token = 0;
   int   burst_left = 0;
   int   cells_sent = 0;
   int   quiet = 0;
   logic [CFG_W-1:0] grid_rows_now;
   logic [CFG_W-1:0] grid_cols_now;

   mxs_req_if req_bus ();
   mxs_rsp_if rsp_bus ();
   mxs_csr_if csr_bus ();

   max_3x3_window_sum i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mxs_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (mismatches),
      .results_owed (owed)
   );

   always #5 clock = ~clock;

   function automatic int grid_span(input logic [CFG_W-1:0] v, input int cap);
      if (v == 0) return 1;
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   function automatic logic [CELL_W-1:0] pick_value(input fill_type fill);
      case (fill)
         FILL_LOW:    return CELL_W'($urandom_range(0, 2));
         FILL_SPARSE: return ($urandom_range(0, 7) == 0) ? CELL_W'($urandom_range(0, 255)) : '0;
         FILL_ZERO:   return '0;
         FILL_HIGH:   return CELL_W'($urandom_range(240, 255));
         default:     return CELL_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic fill_type pick_fill();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return FILL_ANY;
         4, 5:       return FILL_LOW;
         6:          return FILL_SPARSE;
         7:          return FILL_ZERO;
         default:    return FILL_HIGH;
      endcase
   endfunction

   task automatic pick_grid(output logic [CFG_W-1:0] r, output logic [CFG_W-1:0] c);
      case ($urandom_range(0, 19))
         0: begin
            r = $urandom_range(0, 1) ? CFG_W'(128) : CFG_W'($urandom_range(129, 255));
            c = CFG_W'($urandom_range(0, 3));
         end
         1: begin
            c = $urandom_range(0, 1) ? CFG_W'(128) : CFG_W'($urandom_range(129, 255));
            r = CFG_W'($urandom_range(0, 3));
         end
         2: begin
            r = CFG_W'($urandom_range(0, 2));
            c = CFG_W'($urandom_range(0, 10));
         end
         3: begin
            r = CFG_W'($urandom_range(0, 10));
            c = CFG_W'($urandom_range(0, 2));
         end
         default: begin
            r = CFG_W'($urandom_range(3, 10));
            c = CFG_W'($urandom_range(3, 10));
         end
      endcase
   endtask

   task automatic send_word(input logic [CELL_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0
             : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.cell_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      cells_sent++;
   endtask

   task automatic send_frame(input fill_type fill);
      repeat (grid_span(grid_rows_now, ROWS_CAP) * grid_span(grid_cols_now, COL_CAP))
         send_word(pick_value(fill));
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_GRID_ROWS;
      csr_bus.data  <= r;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= CSR_GRID_COLS;
      csr_bus.data  <= c;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      grid_rows_now = r;
      grid_cols_now = c;
   endtask

   // idle the input, wait for every owed word, then let the pipe empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      rx_mode_type mode;
      int          span;
      int          seen;
      rsp_bus.ready <= 1'b0;
      mode = RX_OPEN;
      span = 0;
      seen = 0;
      forever begin
         @(posedge clock);
         if (hold_token != seen) begin
            seen = hold_token;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(32, 256);
         end
         span--;
         case (mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
            default:   rsp_bus.ready <= (span % 8) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [CFG_W-1:0] r;
      logic [CFG_W-1:0] c;
      int               phase_no;
      int               frames;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cell_value <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_GRID_ROWS;
      csr_bus.data       <= '0;
      grid_rows_now = GRID_RESET;
      grid_cols_now = GRID_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // high words (240 to 255), then a frame with nothing found
      send_frame(FILL_HIGH);
      send_frame(FILL_ZERO);
      settle();
      // zero size acts as a single cell
      set_grid('0, '0);
      send_word(8'hFF);
      settle();
      // too few rows, oversize width, then shrink inside the frame
      set_grid(CFG_W'(2), CFG_W'(200));
      repeat (3) send_word(pick_value(FILL_ANY));
      settle();
      set_grid(CFG_W'(1), CFG_W'(3));
      send_word(pick_value(FILL_HIGH));

      phase_no = 0;
      while (cells_sent < TOTAL_CELLS) begin
         settle();
         if (phase_no % 25 == 0) begin
            // one-cell frames against a stalled receiver fill the result buffer
            set_grid('0, '0);
            hold_token <= hold_token + 1;
            repeat (40) send_word(pick_value(FILL_ANY));
         end else begin
            pick_grid(r, c);
            set_grid(r, c);
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, grid_span(r, ROWS_CAP) * grid_span(c, COL_CAP)))
                  send_word(pick_value(pick_fill()));
               settle();
               pick_grid(r, c);
               set_grid(r, c);
            end
            frames = (grid_span(r, ROWS_CAP) * grid_span(c, COL_CAP) > 64) ? 1
                   : $urandom_range(1, 4);
            repeat (frames) send_frame(pick_fill());
         end
         phase_no++;
      end
      settle();

      if (mismatches == 0 && owed == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
